// File: rtl/fpsa_pkg.sv
// ----------------------------------------------------------------------------
// fpsa_pkg
// Shared types and constants for the free page stack allocator.
// ----------------------------------------------------------------------------
package fpsa_pkg;

   localparam int MAX_PAGES = 32768;
   localparam int PAGE_W    = 44;
   localparam int OFS_W     = $clog2(MAX_PAGES);
   localparam int CNT_W     = $clog2(MAX_PAGES + 1);
   localparam int DATA_W    = 64;
   localparam int ADDR_W    = 4;

   localparam logic [PAGE_W-1:0] RESET_PAGE = PAGE_W'(524288);

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_ALLOCATED = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FREED     = 2'd2,
      ST_REJECTED  = 2'd3
   } status_type;

   // register index, taken from paddr bit 3 (8-byte spacing)
   typedef enum logic {
      REG_FIRST_PAGE = 1'b0,
      REG_END_PAGE   = 1'b1
   } reg_index_type;

   // current region as seen by the datapath
   typedef struct packed {
      logic [PAGE_W-1:0] first_page;
      logic [CNT_W-1:0]  size;
   } region_type;

   // pool rebuild request from the register block
   typedef struct packed {
      logic             init;
      logic [CNT_W-1:0] size;
   } pool_init_type;

   // classified request passed from front to back
   typedef struct packed {
      opcode_type       op;
      logic             in_region;
      logic [OFS_W-1:0] offset;
   } cmd_type;

endpackage

// File: rtl/fpsa_if.sv
// ----------------------------------------------------------------------------
// fpsa_req_if / fpsa_rsp_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
interface fpsa_req_if;
   import fpsa_pkg::*;

   logic              valid;
   logic              ready;
   logic              opcode;
   logic [PAGE_W-1:0] page;

   modport source (output valid, output opcode, output page, input ready);
   modport sink   (input valid, input opcode, input page, output ready);
endinterface

interface fpsa_rsp_if;
   import fpsa_pkg::*;

   logic              valid;
   logic              ready;
   logic [PAGE_W-1:0] page_out;
   logic [1:0]        status;

   modport source (output valid, output page_out, output status, input ready);
   modport sink   (input valid, input page_out, input status, output ready);
endinterface

// File: rtl/fpsa_csr.sv
// ----------------------------------------------------------------------------
// fpsa_csr
// APB register block: region bounds, region size and pool rebuild request.
// ----------------------------------------------------------------------------
module fpsa_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [fpsa_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [fpsa_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [fpsa_pkg::DATA_W-1:0]  csr_prdata,
   output logic                         csr_pready,
   output fpsa_pkg::region_type         region,
   output fpsa_pkg::pool_init_type      pool_init
);
   import fpsa_pkg::*;

   logic [PAGE_W-1:0] first_ff, first_in;
   logic [PAGE_W-1:0] end_ff, end_in;
   logic [CNT_W-1:0]  size_ff, size_in;
   logic [PAGE_W-1:0] span;
   logic              wr_en;
   reg_index_type     idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign idx        = reg_index_type'(csr_paddr[3]);

   always_comb begin
      first_in = first_ff;
      end_in   = end_ff;
      if (wr_en) begin
         unique case (idx)
            REG_FIRST_PAGE: first_in = csr_pwdata[PAGE_W-1:0];
            REG_END_PAGE:   end_in   = csr_pwdata[PAGE_W-1:0];
            default:        first_in = first_ff;
         endcase
      end
      // size = end - first, capped, zero when the region is empty
      span = end_in - first_in;
      if (end_in <= first_in) begin
         size_in = '0;
      end else if (span > PAGE_W'(MAX_PAGES)) begin
         size_in = CNT_W'(MAX_PAGES);
      end else begin
         size_in = span[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= RESET_PAGE;
         end_ff   <= RESET_PAGE;
         size_ff  <= '0;
      end else begin
         first_ff <= first_in;
         end_ff   <= end_in;
         size_ff  <= size_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_FIRST_PAGE: csr_prdata = DATA_W'(first_ff);
         REG_END_PAGE:   csr_prdata = DATA_W'(end_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign region.first_page = first_ff;
   assign region.size       = size_ff;
   assign pool_init.init    = wr_en;
   assign pool_init.size    = size_in;

endmodule

// File: rtl/fpsa_front.sv
// ----------------------------------------------------------------------------
// fpsa_front
// Request intake: range-checks freed pages and forms a command for the queue.
// ----------------------------------------------------------------------------
module fpsa_front (
   fpsa_req_if.sink              req_if,
   input  fpsa_pkg::region_type  region,
   output logic                  cmd_valid,
   output fpsa_pkg::cmd_type     cmd,
   input  logic                  cmd_ready
);
   import fpsa_pkg::*;

   logic [PAGE_W-1:0] diff;

   assign diff = req_if.page - region.first_page;

   always_comb begin
      cmd.op        = opcode_type'(req_if.opcode);
      cmd.in_region = (req_if.page >= region.first_page) &&
                      (diff < PAGE_W'(region.size));
      cmd.offset    = diff[OFS_W-1:0];
   end

   assign cmd_valid    = req_if.valid;
   assign req_if.ready = cmd_ready;

endmodule

// File: rtl/fpsa_queue.sv
// ----------------------------------------------------------------------------
// fpsa_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module fpsa_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_valid,
   input  fpsa_pkg::cmd_type  wr_cmd,
   output logic               wr_ready,
   output logic               rd_valid,
   output fpsa_pkg::cmd_type  rd_cmd,
   input  logic               rd_ready
);
   import fpsa_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;

   assign wr_ready = (fill_ff != 2'd2);
   assign rd_valid = (fill_ff != 2'd0);
   assign rd_cmd   = slot_ff[rd_ptr_ff];
   assign push     = wr_valid & wr_ready;
   assign pop      = rd_valid & rd_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

// File: rtl/fpsa_back.sv
// ----------------------------------------------------------------------------
// fpsa_back
// Stack engine: freed-page memory, stack count, watermark, response register.
// ----------------------------------------------------------------------------
module fpsa_back (
   input  logic                     clock,
   input  logic                     reset,
   input  fpsa_pkg::region_type     region,
   input  fpsa_pkg::pool_init_type  pool_init,
   input  logic                     cmd_valid,
   input  fpsa_pkg::cmd_type        cmd,
   output logic                     cmd_ready,
   fpsa_rsp_if.source               rsp_if
);
   import fpsa_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  mark_ff, mark_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   status_type        status_ff, status_in;

   logic [OFS_W-1:0]  mem [MAX_PAGES];
   logic [OFS_W-1:0]  rd_data_ff;
   logic [OFS_W-1:0]  rd_addr;
   logic              rd_en, wr_en;
   logic              take;
   logic [CNT_W-1:0]  mark_dec;
   logic [CNT_W-1:0]  count_dec;

   assign mark_dec  = mark_ff - CNT_W'(1);
   assign count_dec = count_ff - CNT_W'(1);
   assign rd_addr   = count_dec[OFS_W-1:0];
   assign take      = (state_ff == S_IDLE) && cmd_valid &&
                      (!rsp_valid_ff || rsp_if.ready);
   assign cmd_ready = take;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      mark_in      = mark_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_if.ready;
      page_in      = page_ff;
      status_in    = status_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               if (cmd.op == OP_FREE) begin
                  rsp_valid_in = 1'b1;
                  page_in      = '0;
                  if (cmd.in_region && (count_ff != CNT_W'(MAX_PAGES))) begin
                     wr_en     = 1'b1;
                     count_in  = count_ff + CNT_W'(1);
                     status_in = ST_FREED;
                  end else begin
                     status_in = ST_REJECTED;
                  end
               end else if (count_ff != '0) begin
                  rd_en    = 1'b1;
                  count_in = count_dec;
                  state_in = S_READ;
               end else if (mark_ff != '0) begin
                  mark_in      = mark_dec;
                  rsp_valid_in = 1'b1;
                  page_in      = region.first_page + PAGE_W'(mark_dec);
                  status_in    = ST_ALLOCATED;
               end else begin
                  rsp_valid_in = 1'b1;
                  page_in      = '0;
                  status_in    = ST_EMPTY;
               end
            end
         end
         S_READ: begin
            // response slot was freed when this pop was taken
            rsp_valid_in = 1'b1;
            page_in      = region.first_page + PAGE_W'(rd_data_ff);
            status_in    = ST_ALLOCATED;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      if (pool_init.init) begin
         count_in = '0;
         mark_in  = pool_init.size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         mark_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         mark_ff      <= mark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      page_ff   <= page_in;
      status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[OFS_W-1:0]] <= cmd.offset;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.page_out = page_ff;
   assign rsp_if.status   = status_ff;

endmodule

// File: rtl/free_page_stack_allocator.sv
// ----------------------------------------------------------------------------
// free_page_stack_allocator
// Page frame allocator: LIFO of freed frames plus a watermark over the region.
// ----------------------------------------------------------------------------
// Hands out and takes back page frames of the region [first_page, end_page),
// at most MAX_PAGES frames. An allocate transaction returns the most recently
// freed frame; with no freed frame it returns untouched frames from the top of
// the region down, and once both are exhausted it answers page 0 with status
// "empty". A free transaction pushes the frame, or is rejected when the frame
// lies outside the region or the stack is full; double frees are not caught.
// Writing either region register rebuilds the pool, as reset does; write only
// while no transaction is in flight. Rate: the front side takes a request
// every cycle while its two-entry queue has room; the back side retires a
// free, a watermark allocate or an empty answer straight from its idle
// state, and a pop of a freed frame through a read state because of the
// registered read of the stack memory. The stack memory needs no clearing
// pass: only pushed entries are ever read.
// ----------------------------------------------------------------------------
module free_page_stack_allocator (
   input  logic                         clock,
   input  logic                         reset,
   fpsa_req_if.sink                     req_if,
   fpsa_rsp_if.source                   rsp_if,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [fpsa_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [fpsa_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [fpsa_pkg::DATA_W-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import fpsa_pkg::*;

   region_type    region;
   pool_init_type pool_init;

   // front -> queue
   logic    fq_valid, fq_ready;
   cmd_type fq_cmd;
   // queue -> back
   logic    qb_valid, qb_ready;
   cmd_type qb_cmd;

   // Region registers; a write also pulses the pool rebuild.
   fpsa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .region      (region),
      .pool_init   (pool_init)
   );

   // Front: range check of freed frames, offset into the region.
   fpsa_front u_front (
      .req_if    (req_if),
      .region    (region),
      .cmd_valid (fq_valid),
      .cmd       (fq_cmd),
      .cmd_ready (fq_ready)
   );

   // Decouples intake from the stack engine.
   fpsa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fq_valid),
      .wr_cmd   (fq_cmd),
      .wr_ready (fq_ready),
      .rd_valid (qb_valid),
      .rd_cmd   (qb_cmd),
      .rd_ready (qb_ready)
   );

   // Back: push/pop on the stack memory, watermark, response register.
   fpsa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .region    (region),
      .pool_init (pool_init),
      .cmd_valid (qb_valid),
      .cmd       (qb_cmd),
      .cmd_ready (qb_ready),
      .rsp_if    (rsp_if)
   );

endmodule
